### rtl/sbly_pkg.sv
// ----------------------------------------------------------------------------
// sbly_pkg
// Shared types and constants for the Birks light yield block.
// ----------------------------------------------------------------------------
package sbly_pkg;

  // Width of the running energy and light sums
  localparam int SUM_WIDTH = 40;
  localparam int OUT_W     = 40;

  // Datapath widths
  localparam int D_W   = 42;   // dE/dx quotient, edep*2^16 / (100*step) < 2^42
  localparam int U_W   = 50;   // c2*D / 2^40 < 2^50
  localparam int ACC_W = 92;   // widest product, u*D < 2^92

  // Divider iteration counts (remainder preloaded with leading dividend bits)
  localparam int DIV1_ITER = 42;
  localparam int DIV2_ITER = 32;
  localparam int MUL_STEPS = 4;  // 2x2 partial products of 32x32
  localparam int CNT_W     = 6;

  localparam logic [63:0] ONE_Q24 = 64'd16777216;

  // Configuration register indexes and reset values
  localparam logic [1:0] REG_C1  = 2'd0;
  localparam logic [1:0] REG_C1H = 2'd1;
  localparam logic [1:0] REG_C2  = 2'd2;

  localparam logic [31:0] C1_RESET  = 32'd211340;
  localparam logic [31:0] C1H_RESET = 32'd120766;
  localparam logic [47:0] C2_RESET  = 48'd2537183070;

  // Multiply operand select
  typedef enum logic [1:0] {
    MOP_C1,
    MOP_C2,
    MOP_U
  } mul_op_t;

  // Controller to datapath commands
  typedef struct packed {
    logic    load;        // take the input item
    logic    div_step;    // one radix-2 divider iteration
    logic    mul_pp;      // form one partial product
    logic    mul_clr;     // clear the product accumulator
    logic    mul_acc;     // add the registered partial product
    logic    mul_wb;      // write back the finished product
    mul_op_t mul_op;
    logic [1:0] mul_idx;
    logic    div2_load;   // preload divider for the light quotient
    logic    light_add;   // add quotient to the light sum
    logic    emit;        // load the output register
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic light_go;   // input item is charged and has nonzero length
    logic emit_req;   // leaving step with nonzero energy sum
  } dp_sts_t;

endpackage

### rtl/scintillator_birks_light_yield.sv
// ----------------------------------------------------------------------------
// scintillator_birks_light_yield: Birks-quenched light yield per step.
// Charged step of nonzero length: a radix-2 divider (42 + 32 iterations) and
// three 4-product multiplies; other steps go straight to finish. A step with
// a point to emit waits in finish while an earlier point is still held.
// Sync active-low reset: sums, track number cleared, coefficients at defaults.
// ----------------------------------------------------------------------------
module scintillator_birks_light_yield import sbly_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration write port
  input  logic                 cfg_wr_en,
  input  logic [1:0]           cfg_index,
  input  logic [47:0]          cfg_data,
  // step items in
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [31:0]          in_edep_ev,
  input  logic [31:0]          in_step_um,
  input  logic signed [7:0]    in_charge,
  input  logic [23:0]          in_track_id,
  input  logic                 in_entering,
  input  logic                 in_leaving,
  // point items out
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [23:0]          out_point_track,
  output logic [OUT_W-1:0]     out_point_energy_ev,
  output logic [OUT_W-1:0]     out_point_light_ev
);

  // Flow for one charged step:
  //   accept      : energy sum updated (cleared first on entering), divider
  //                 preloaded with edep*2^16 / (100*step)
  //   divide      : dE/dx quotient D
  //   multiply    : t1 = c1*D, u = c2*D, t2 = u*D, each as four 32x32
  //                 partial products with a registered product stage
  //   divide light: light = edep*2^24 / (2^24 + t1/2^16 + t2/2^16)
  //   accumulate  : saturating add into the light sum
  //   finish      : a leaving step with nonzero energy loads the output
  //                 register; it waits there only while a previous point
  //                 is still unaccepted.
  // Neutral or zero-length steps skip straight to finish.
  // The output register lets the next step be accepted while a point waits.

  dp_cmd_t cmd;
  dp_sts_t sts;

  sbly_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sbly_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_edep_ev          (in_edep_ev),
    .in_step_um          (in_step_um),
    .in_charge           (in_charge),
    .in_track_id         (in_track_id),
    .in_entering         (in_entering),
    .in_leaving          (in_leaving),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_point_track     (out_point_track),
    .out_point_energy_ev (out_point_energy_ev),
    .out_point_light_ev  (out_point_light_ev)
  );

`ifndef NO_ASSERTIONS
  // a point is only produced for a leaving step with energy
  a_emit_req: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.emit_req)
    else $error("point emitted without a pending request");

  // output register never overwritten while a point is still held
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("output register overwritten");

  // item loaded into the datapath only on an input handshake
  a_load_hs: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (in_valid && in_ready))
    else $error("datapath load without input handshake");

  // no new item while the divider is busy
  a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> !in_ready)
    else $error("input ready during divide");
`endif

endmodule

### rtl/sbly_dp.sv
// ----------------------------------------------------------------------------
// sbly_dp
// Datapath: config registers, sums, shared divider and partial product MAC.
// ----------------------------------------------------------------------------
module sbly_dp import sbly_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [1:0]           cfg_index,
  input  logic [47:0]          cfg_data,
  input  logic [31:0]          in_edep_ev,
  input  logic [31:0]          in_step_um,
  input  logic signed [7:0]    in_charge,
  input  logic [23:0]          in_track_id,
  input  logic                 in_entering,
  input  logic                 in_leaving,
  input  dp_cmd_t              cmd,
  output dp_sts_t              sts,
  output logic [23:0]          out_point_track,
  output logic [OUT_W-1:0]     out_point_energy_ev,
  output logic [OUT_W-1:0]     out_point_light_ev
);

  logic [31:0]          c1_r, c1_nxt;
  logic [31:0]          c1h_r, c1h_nxt;
  logic [47:0]          c2_r, c2_nxt;
  logic [23:0]          held_track_r, held_track_nxt;
  logic [SUM_WIDTH-1:0] energy_sum_r, energy_sum_nxt;
  logic [SUM_WIDTH-1:0] light_sum_r, light_sum_nxt;

  logic [31:0]          edep_r, edep_nxt;
  logic                 high_r, high_nxt;
  logic                 leave_r, leave_nxt;
  logic [63:0]          rem_r, rem_nxt;
  logic [63:0]          q_r, q_nxt;
  logic [63:0]          div_r, div_nxt;
  logic [63:0]          pp_r, pp_nxt;
  logic [1:0]           wgt_r, wgt_nxt;
  logic [ACC_W-1:0]     acc_r, acc_nxt;
  logic [U_W-1:0]       u_r, u_nxt;
  logic [63:0]          den_r, den_nxt;
  logic [23:0]          otrk_r, otrk_nxt;
  logic [OUT_W-1:0]     oen_r, oen_nxt;
  logic [OUT_W-1:0]     olt_r, olt_nxt;

  logic [SUM_WIDTH-1:0] e_base;
  logic [SUM_WIDTH:0]   e_add;
  logic [SUM_WIDTH:0]   l_add;
  logic [64:0]          div_sh;
  logic [65:0]          div_diff;
  logic [U_W-1:0]       a_op;
  logic [31:0]          a_ch;
  logic [31:0]          b_ch;
  logic [ACC_W-1:0]     pp_sh;
  logic [63:0]          t2_sat;
  logic [64:0]          den_sum;
  logic [63:0]          step_x100;

  // energy sum with optional clear on entering, saturating
  assign e_base   = in_entering ? '0 : energy_sum_r;
  assign e_add    = {1'b0, e_base} + (SUM_WIDTH+1)'(in_edep_ev);
  assign l_add    = {1'b0, light_sum_r} + (SUM_WIDTH+1)'(q_r[31:0]);

  // step * 100 by shift-add
  assign step_x100 = (64'(in_step_um) << 6) + (64'(in_step_um) << 5)
                   + (64'(in_step_um) << 2);

  // restoring divider trial
  assign div_sh   = {rem_r, q_r[63]};
  assign div_diff = {1'b0, div_sh} - {2'b00, div_r};

  // multiplier operands: quotient D sits in q_r after the first divide
  always_comb begin
    case (cmd.mul_op)
      MOP_C1:  a_op = U_W'(high_r ? c1h_r : c1_r);
      MOP_C2:  a_op = U_W'(c2_r);
      MOP_U:   a_op = u_r;
      default: a_op = '0;
    endcase
  end

  assign a_ch = cmd.mul_idx[1] ? 32'(a_op[U_W-1:32]) : a_op[31:0];
  assign b_ch = cmd.mul_idx[0] ? 32'(q_r[D_W-1:32]) : q_r[31:0];

  always_comb begin
    case (wgt_r)
      2'd0:    pp_sh = ACC_W'(pp_r);
      2'd1:    pp_sh = ACC_W'(pp_r) << 32;
      default: pp_sh = ACC_W'(pp_r) << 64;
    endcase
  end

  // t2 = u*D / 2^16 saturates at 64 bits
  assign t2_sat  = (|acc_r[ACC_W-1:80]) ? '1 : acc_r[79:16];
  assign den_sum = {1'b0, den_r} + {1'b0, t2_sat};

  assign sts.light_go = (in_charge != 8'sd0) && (in_step_um != 32'd0);
  assign sts.emit_req = leave_r && (energy_sum_r != '0);

  always_comb begin
    c1_nxt         = c1_r;
    c1h_nxt        = c1h_r;
    c2_nxt         = c2_r;
    held_track_nxt = held_track_r;
    energy_sum_nxt = energy_sum_r;
    light_sum_nxt  = light_sum_r;
    edep_nxt       = edep_r;
    high_nxt       = high_r;
    leave_nxt      = leave_r;
    rem_nxt        = rem_r;
    q_nxt          = q_r;
    div_nxt        = div_r;
    pp_nxt         = pp_r;
    wgt_nxt        = wgt_r;
    acc_nxt        = acc_r;
    u_nxt          = u_r;
    den_nxt        = den_r;
    otrk_nxt       = otrk_r;
    oen_nxt        = oen_r;
    olt_nxt        = olt_r;

    if (cfg_wr_en) begin
      case (cfg_index)
        REG_C1:  c1_nxt  = cfg_data[31:0];
        REG_C1H: c1h_nxt = cfg_data[31:0];
        REG_C2:  c2_nxt  = cfg_data;
        default: ;
      endcase
    end

    if (cmd.load) begin
      energy_sum_nxt = e_add[SUM_WIDTH] ? '1 : e_add[SUM_WIDTH-1:0];
      if (in_entering) begin
        light_sum_nxt  = '0;
        held_track_nxt = in_track_id;
      end
      edep_nxt  = in_edep_ev;
      high_nxt  = !((in_charge == 8'sd1) || (in_charge == -8'sd1));
      leave_nxt = in_leaving;
      // top 6 dividend bits are below any divisor of at least 100
      rem_nxt   = 64'(in_edep_ev[31:26]);
      q_nxt     = {in_edep_ev[25:0], 38'd0};
      div_nxt   = step_x100;
    end

    if (cmd.div_step) begin
      rem_nxt = div_diff[65] ? div_sh[63:0] : div_diff[63:0];
      q_nxt   = {q_r[62:0], ~div_diff[65]};
    end

    if (cmd.mul_pp) begin
      pp_nxt  = a_ch * b_ch;
      wgt_nxt = 2'(cmd.mul_idx[1]) + 2'(cmd.mul_idx[0]);
    end

    if (cmd.mul_clr) begin
      acc_nxt = '0;
    end else if (cmd.mul_acc) begin
      acc_nxt = acc_r + pp_sh;
    end

    if (cmd.mul_wb) begin
      case (cmd.mul_op)
        MOP_C1:  den_nxt = ONE_Q24 + 64'(acc_r[73:16]);
        MOP_C2:  u_nxt   = acc_r[89:40];
        MOP_U:   den_nxt = den_sum[64] ? '1 : den_sum[63:0];
        default: ;
      endcase
    end

    if (cmd.div2_load) begin
      // den >= 2^24, so the top 24 dividend bits go straight in
      rem_nxt = 64'(edep_r[31:8]);
      q_nxt   = {edep_r[7:0], 56'd0};
      div_nxt = den_r;
    end

    if (cmd.light_add) begin
      light_sum_nxt = l_add[SUM_WIDTH] ? '1 : l_add[SUM_WIDTH-1:0];
    end

    if (cmd.emit) begin
      otrk_nxt = held_track_r;
      oen_nxt  = OUT_W'(energy_sum_r);
      olt_nxt  = OUT_W'(light_sum_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r         <= C1_RESET;
      c1h_r        <= C1H_RESET;
      c2_r         <= C2_RESET;
      held_track_r <= '0;
      energy_sum_r <= '0;
      light_sum_r  <= '0;
    end else begin
      c1_r         <= c1_nxt;
      c1h_r        <= c1h_nxt;
      c2_r         <= c2_nxt;
      held_track_r <= held_track_nxt;
      energy_sum_r <= energy_sum_nxt;
      light_sum_r  <= light_sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    edep_r  <= edep_nxt;
    high_r  <= high_nxt;
    leave_r <= leave_nxt;
    rem_r   <= rem_nxt;
    q_r     <= q_nxt;
    div_r   <= div_nxt;
    pp_r    <= pp_nxt;
    wgt_r   <= wgt_nxt;
    acc_r   <= acc_nxt;
    u_r     <= u_nxt;
    den_r   <= den_nxt;
    otrk_r  <= otrk_nxt;
    oen_r   <= oen_nxt;
    olt_r   <= olt_nxt;
  end

  assign out_point_track     = otrk_r;
  assign out_point_energy_ev = oen_r;
  assign out_point_light_ev  = olt_r;

endmodule

### rtl/sbly_ctrl.sv
// ----------------------------------------------------------------------------
// sbly_ctrl
// Sequencer for divides and multiplies, input and output handshakes.
// ----------------------------------------------------------------------------
module sbly_ctrl import sbly_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV1,
    S_MUL,
    S_MWB,
    S_DIV2_LD,
    S_DIV2,
    S_LIGHT,
    S_FINISH
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  mul_op_t          op_r, op_nxt;
  logic             out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    op_nxt        = op_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.mul_op    = op_r;
    cmd.mul_idx   = cnt_r[1:0];

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = sts.light_go ? S_DIV1 : S_FINISH;
        end
      end
      S_DIV1: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV1_ITER - 1)) begin
          cnt_nxt   = '0;
          op_nxt    = MOP_C1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_pp  = (cnt_r < CNT_W'(MUL_STEPS));
        cmd.mul_clr = (cnt_r == '0);
        cmd.mul_acc = (cnt_r != '0);
        cnt_nxt     = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(MUL_STEPS)) begin
          state_nxt = S_MWB;
        end
      end
      S_MWB: begin
        cmd.mul_wb = 1'b1;
        cnt_nxt    = '0;
        case (op_r)
          MOP_C1: begin
            op_nxt    = MOP_C2;
            state_nxt = S_MUL;
          end
          MOP_C2: begin
            op_nxt    = MOP_U;
            state_nxt = S_MUL;
          end
          default: begin
            state_nxt = S_DIV2_LD;
          end
        endcase
      end
      S_DIV2_LD: begin
        cmd.div2_load = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = S_DIV2;
      end
      S_DIV2: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV2_ITER - 1)) begin
          state_nxt = S_LIGHT;
        end
      end
      S_LIGHT: begin
        cmd.light_add = 1'b1;
        state_nxt     = S_FINISH;
      end
      S_FINISH: begin
        if (!sts.emit_req) begin
          state_nxt = S_IDLE;
        end else if (!out_valid_r || out_ready) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      op_r        <= MOP_C1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
